/* design/avb_pkg.sv */
// Shared constants, types, state codes and constant tables for the acid bass voice.
package avb_pkg;

	// Sizing
	localparam int SAMPLE_WIDTH    = 24;
	localparam int EXP_TABLE_DEPTH = 1024;
	localparam int COS_TABLE_DEPTH = 1024;
	localparam int EXP_AW          = $clog2(EXP_TABLE_DEPTH);
	localparam int COS_AW          = $clog2(COS_TABLE_DEPTH);

	// Datapath widths
	localparam int EXP_W   = 25;  // k, Q0.24, up to 1.0
	localparam int COS_W   = 26;  // cos, signed Q0.24
	localparam int W_W     = 25;  // cutoff angle, base + envelope
	localparam int X_W     = 41;  // angle times reciprocal resonance
	localparam int FRAC_W  = 30;  // fraction of w / pi
	localparam int ENV_W   = 24;
	localparam int A_W     = 27;
	localparam int B_W     = 26;
	localparam int C_W     = 28;
	localparam int PH_W    = 24;
	localparam int MUL_W   = 33;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int ACC_W   = (SAMPLE_WIDTH + 28 > 50) ? SAMPLE_WIDTH + 28 : 50;
	localparam int XD_W    = X_W + $clog2(EXP_TABLE_DEPTH + 1);
	localparam int EXH_W   = XD_W - 38;
	localparam int JD_W    = FRAC_W + $clog2(COS_TABLE_DEPTH + 1);

	// Config port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;

	// Fixed-point constants
	localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
	localparam longint      Q30_ONE    = 64'sd1073741824;
	localparam longint      TWO_PI_Q30 = 64'sd6746518852;
	localparam logic signed [PH_W:0]  PH_HALF = 25'sd4194304;
	localparam logic signed [PH_W:0]  PH_ONE  = 25'sd8388608;
	localparam logic signed [C_W-1:0] C_ONE   = 28'sd16777216;
	localparam logic signed [ACC_W-1:0] Y_MAX =
		ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RUN            = 3'd0,
		REG_PHASE_STEP     = 3'd1,
		REG_BASE_CUTOFF    = 3'd2,
		REG_ENV_DEPTH      = 3'd3,
		REG_ENV_DECAY_MULT = 3'd4,
		REG_INV_RES_COEFF  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic        run;
		logic [22:0] phase_step;
		logic [23:0] base_cutoff;
		logic [23:0] env_depth;
		logic [24:0] env_decay_mult;
		logic [15:0] inv_res_coeff;
	} cfg_t;

	// Datapath operations, one per sequencer step
	typedef enum logic [3:0] {
		OP_NONE,
		OP_X,
		OP_COS,
		OP_ENV,
		OP_KK,
		OP_A,
		OP_Y1,
		OP_Y2,
		OP_PH,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		logic   load;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic run;
		logic out_free;
	} dp_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MX,
		ST_MC,
		ST_ME,
		ST_MK,
		ST_MA,
		ST_MY1,
		ST_MY2,
		ST_MP,
		ST_DONE
	} state_t;

	// exp(-16 i / D) in Q0.24: Taylor series in Q30, squared four times
	function automatic longint exp_entry(longint i);
		longint f;
		longint term;
		longint sum;
		f = (i <<< 30) / EXP_TABLE_DEPTH;
		term = Q30_ONE;
		sum = Q30_ONE;
		for (int n = 1; n <= 12; n++) begin
			term = (term * f) >>> 30;
			case (n)
				1:  term = term / 1;
				2:  term = term / 2;
				3:  term = term / 3;
				4:  term = term / 4;
				5:  term = term / 5;
				6:  term = term / 6;
				7:  term = term / 7;
				8:  term = term / 8;
				9:  term = term / 9;
				10: term = term / 10;
				11: term = term / 11;
				default: term = term / 12;
			endcase
			sum = n[0] ? sum - term : sum + term;
		end
		if (sum < 0) sum = 0;
		if (sum > Q30_ONE) sum = Q30_ONE;
		for (int n = 0; n < 4; n++)
			sum = (sum * sum + (Q30_ONE >>> 1)) >>> 30;
		return (sum + 32) >>> 6;
	endfunction

	// cos(2 pi j / D) in signed Q0.24, folded to the first quadrant
	function automatic longint cos_entry(longint j);
		longint v;
		longint x;
		longint x2;
		longint term;
		longint sum;
		logic   neg;
		v = (j <<< 30) / COS_TABLE_DEPTH;
		neg = 1'b0;
		term = Q30_ONE;
		sum = Q30_ONE;
		if (v >= (Q30_ONE >>> 1)) v = Q30_ONE - v;
		if (v > (Q30_ONE >>> 2)) begin
			neg = 1'b1;
			v = (Q30_ONE >>> 1) - v;
		end
		x = (v * TWO_PI_Q30) >>> 30;
		x2 = (x * x) >>> 30;
		for (int n = 1; n <= 8; n++) begin
			term = (term * x2) >>> 30;
			case (n)
				1: term = term / 2;
				2: term = term / 12;
				3: term = term / 30;
				4: term = term / 56;
				5: term = term / 90;
				6: term = term / 132;
				7: term = term / 182;
				default: term = term / 240;
			endcase
			sum = n[0] ? sum - term : sum + term;
		end
		if (sum < 0) sum = 0;
		sum = (sum + 32) >>> 6;
		if (sum > 64'sd16777216) sum = 64'sd16777216;
		return neg ? -sum : sum;
	endfunction

	typedef logic [EXP_W-1:0]        exp_tab_t [EXP_TABLE_DEPTH];
	typedef logic signed [COS_W-1:0] cos_tab_t [COS_TABLE_DEPTH];

	function automatic exp_tab_t gen_exp_tab();
		exp_tab_t t;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++)
			t[i] = EXP_W'(exp_entry(longint'(i)));
		return t;
	endfunction

	function automatic cos_tab_t gen_cos_tab();
		cos_tab_t t;
		for (int i = 0; i < COS_TABLE_DEPTH; i++)
			t[i] = COS_W'(cos_entry(longint'(i)));
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = gen_exp_tab();
	localparam cos_tab_t COS_TAB = gen_cos_tab();

endpackage

/* design/avb_ifs.sv */
// Channel interfaces: sample tick requests, voice results and config writes.
interface avb_tick_if;
	logic valid;
	logic ready;
	logic retrigger;
	logic last_in_block;
	modport source (output valid, retrigger, last_in_block, input ready);
	modport sink (input valid, retrigger, last_in_block, output ready);
endinterface

interface avb_voice_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [avb_pkg::SAMPLE_WIDTH-1:0] sample;
	logic                                    block_end;
	modport source (output valid, sample, block_end, input ready);
	modport sink (input valid, sample, block_end, output ready);
endinterface

interface avb_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [avb_pkg::CFG_IDX_W-1:0]  index;
	logic [avb_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/avb_regs.sv */
// Configuration register file, written through the config channel.
module avb_regs (
	input  logic          clk,
	input  logic          arst_n,
	avb_cfg_if.sink       cfg,
	output avb_pkg::cfg_t regs
);

	avb_pkg::cfg_t cfg_q;

	// Writes are always taken
	assign cfg.ready = 1'b1;
	assign regs = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{run: 1'b0, phase_step: '0, base_cutoff: '0, env_depth: '0,
				env_decay_mult: '0, inv_res_coeff: 16'd4096};
		end else if (cfg.valid) begin
			unique case (avb_pkg::cfg_idx_t'(cfg.index))
				avb_pkg::REG_RUN:            cfg_q.run <= cfg.data[0];
				avb_pkg::REG_PHASE_STEP:     cfg_q.phase_step <= cfg.data[22:0];
				avb_pkg::REG_BASE_CUTOFF:    cfg_q.base_cutoff <= cfg.data[23:0];
				avb_pkg::REG_ENV_DEPTH:      cfg_q.env_depth <= cfg.data[23:0];
				avb_pkg::REG_ENV_DECAY_MULT: cfg_q.env_decay_mult <= cfg.data[24:0];
				avb_pkg::REG_INV_RES_COEFF:  cfg_q.inv_res_coeff <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

endmodule

/* design/avb_ctrl.sv */
// Sequencer that steps the shared multiplier through one sample.
module avb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  avb_pkg::dp_status_t status,
	output avb_pkg::dp_cmd_t    cmd
);

	avb_pkg::state_t state_q;
	avb_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= avb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and datapath command
	always_comb begin
		state_nxt = state_q;
		in_ready = 1'b0;
		cmd.load = 1'b0;
		cmd.op = avb_pkg::OP_NONE;
		unique case (state_q)
			avb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				// a tick while stopped is consumed with no effect
				if (in_valid && status.run) begin
					cmd.load = 1'b1;
					state_nxt = avb_pkg::ST_MX;
				end
			end
			avb_pkg::ST_MX: begin
				cmd.op = avb_pkg::OP_X;
				state_nxt = avb_pkg::ST_MC;
			end
			avb_pkg::ST_MC: begin
				cmd.op = avb_pkg::OP_COS;
				state_nxt = avb_pkg::ST_ME;
			end
			avb_pkg::ST_ME: begin
				cmd.op = avb_pkg::OP_ENV;
				state_nxt = avb_pkg::ST_MK;
			end
			avb_pkg::ST_MK: begin
				cmd.op = avb_pkg::OP_KK;
				state_nxt = avb_pkg::ST_MA;
			end
			avb_pkg::ST_MA: begin
				cmd.op = avb_pkg::OP_A;
				state_nxt = avb_pkg::ST_MY1;
			end
			avb_pkg::ST_MY1: begin
				cmd.op = avb_pkg::OP_Y1;
				state_nxt = avb_pkg::ST_MY2;
			end
			avb_pkg::ST_MY2: begin
				cmd.op = avb_pkg::OP_Y2;
				state_nxt = avb_pkg::ST_MP;
			end
			avb_pkg::ST_MP: begin
				cmd.op = avb_pkg::OP_PH;
				state_nxt = avb_pkg::ST_DONE;
			end
			avb_pkg::ST_DONE: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					cmd.op = avb_pkg::OP_OUT;
					state_nxt = avb_pkg::ST_IDLE;
				end
			end
			default: state_nxt = avb_pkg::ST_IDLE;
		endcase
	end

endmodule

/* design/avb_dpath.sv */
// Datapath: shared multiplier, exp and cosine tables, filter state and output register.
module avb_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  avb_pkg::cfg_t       cfg,
	input  avb_pkg::dp_cmd_t    cmd,
	output avb_pkg::dp_status_t status,
	input  logic                retrigger,
	input  logic                last_in_block,
	avb_voice_if.source         voice
);

	localparam int SW = avb_pkg::SAMPLE_WIDTH;

	// Working registers
	logic [avb_pkg::W_W-1:0]            w_q;
	logic [avb_pkg::X_W-1:0]            x_q;
	logic [avb_pkg::FRAC_W-1:0]         frac_q;
	logic [avb_pkg::EXP_AW-1:0]         eidx_q;
	logic [avb_pkg::COS_AW-1:0]         j_q;
	logic [avb_pkg::EXP_W-1:0]          k_q;
	logic signed [avb_pkg::COS_W-1:0]   cs_q;
	logic signed [avb_pkg::A_W-1:0]     a_q;
	logic signed [avb_pkg::B_W-1:0]     b_q;
	logic signed [avb_pkg::C_W-1:0]     c_q;
	logic signed [avb_pkg::ACC_W-1:0]   acc_q;
	logic                               blk_q;

	// Voice state
	logic [avb_pkg::ENV_W-1:0]          env_q;
	logic signed [avb_pkg::PH_W-1:0]    phase_q;
	logic signed [SW-1:0]               y1_q;
	logic signed [SW-1:0]               y2_q;

	// Output register
	logic signed [SW-1:0]               sample_q;
	logic                               block_end_q;
	logic                               out_valid_q;

	// Combinational
	logic signed [avb_pkg::MUL_W-1:0]   mul_a;
	logic signed [avb_pkg::MUL_W-1:0]   mul_b;
	logic signed [avb_pkg::PROD_W-1:0]  prod;
	logic [avb_pkg::XD_W-1:0]           xd;
	logic [avb_pkg::EXH_W-1:0]          e_hi;
	logic                               e_ok;
	logic [avb_pkg::JD_W-1:0]           jd;
	logic [avb_pkg::ENV_W:0]            env_full;
	logic [avb_pkg::ENV_W-1:0]          env_sat;
	logic signed [avb_pkg::ACC_W-1:0]   ysh;
	logic signed [avb_pkg::ACC_W-1:0]   y_full;
	logic signed [SW-1:0]               y_sat;
	logic signed [avb_pkg::PH_W:0]      ph_sum;
	logic signed [avb_pkg::PH_W:0]      ph_wrap;
	logic [avb_pkg::ACC_W-1:0]          prod_acc;

	// Operand select for the shared multiplier
	always_comb begin
		unique case (cmd.op)
			avb_pkg::OP_X: begin
				mul_a = avb_pkg::MUL_W'(w_q);
				mul_b = avb_pkg::MUL_W'(cfg.inv_res_coeff);
			end
			avb_pkg::OP_COS: begin
				mul_a = avb_pkg::MUL_W'(w_q);
				mul_b = avb_pkg::MUL_W'(avb_pkg::INV_PI_Q32);
			end
			avb_pkg::OP_ENV: begin
				mul_a = avb_pkg::MUL_W'(env_q);
				mul_b = avb_pkg::MUL_W'(cfg.env_decay_mult);
			end
			avb_pkg::OP_KK: begin
				mul_a = avb_pkg::MUL_W'(k_q);
				mul_b = avb_pkg::MUL_W'(k_q);
			end
			avb_pkg::OP_A: begin
				mul_a = avb_pkg::MUL_W'(k_q);
				mul_b = avb_pkg::MUL_W'(cs_q);
			end
			avb_pkg::OP_Y1: begin
				mul_a = avb_pkg::MUL_W'(a_q);
				mul_b = avb_pkg::MUL_W'(y1_q);
			end
			avb_pkg::OP_Y2: begin
				mul_a = avb_pkg::MUL_W'(b_q);
				mul_b = avb_pkg::MUL_W'(y2_q);
			end
			avb_pkg::OP_PH: begin
				mul_a = avb_pkg::MUL_W'(c_q);
				mul_b = avb_pkg::MUL_W'(phase_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = avb_pkg::PROD_W'(mul_a) * avb_pkg::PROD_W'(mul_b);
	assign prod_acc = prod[avb_pkg::ACC_W-1:0];

	// Table indexes: exp from w * inv_res, cosine from frac(w / pi)
	assign xd = avb_pkg::XD_W'(x_q) * avb_pkg::XD_W'(avb_pkg::EXP_TABLE_DEPTH);
	assign e_hi = xd[avb_pkg::XD_W-1:38];
	assign e_ok = e_hi < avb_pkg::EXH_W'(avb_pkg::EXP_TABLE_DEPTH);
	assign jd = avb_pkg::JD_W'(frac_q) * avb_pkg::JD_W'(avb_pkg::COS_TABLE_DEPTH);

	// Envelope decay, saturating
	assign env_full = prod[48:24];
	assign env_sat = env_full[avb_pkg::ENV_W] ? '1 : env_full[avb_pkg::ENV_W-1:0];

	// Output scaling and saturation
	assign ysh = acc_q >>> 26;
	always_comb begin
		priority if (ysh > avb_pkg::Y_MAX) y_full = avb_pkg::Y_MAX;
		else if (ysh < avb_pkg::Y_MIN) y_full = avb_pkg::Y_MIN;
		else y_full = ysh;
	end
	assign y_sat = y_full[SW-1:0];

	// Oscillator advance with wrap by one
	assign ph_sum = (avb_pkg::PH_W + 1)'(phase_q) + $signed({2'b00, cfg.phase_step});
	assign ph_wrap = (ph_sum > avb_pkg::PH_HALF) ? ph_sum - avb_pkg::PH_ONE : ph_sum;

	// Working registers and output data, no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q <= avb_pkg::W_W'(cfg.base_cutoff)
				+ avb_pkg::W_W'(retrigger ? cfg.env_depth : env_q);
			blk_q <= last_in_block;
		end
		unique case (cmd.op)
			avb_pkg::OP_X: x_q <= prod[avb_pkg::X_W-1:0];
			avb_pkg::OP_COS: begin
				frac_q <= prod[53:24];
				eidx_q <= e_ok ? e_hi[avb_pkg::EXP_AW-1:0] : '0;
			end
			avb_pkg::OP_ENV: begin
				j_q <= jd[avb_pkg::FRAC_W +: avb_pkg::COS_AW];
				// index past the table means k = 0
				k_q <= e_ok ? avb_pkg::EXP_TAB[eidx_q] : '0;
			end
			avb_pkg::OP_KK: begin
				cs_q <= avb_pkg::COS_TAB[j_q];
				b_q <= avb_pkg::B_W'(0) - avb_pkg::B_W'(prod[48:24]);
			end
			avb_pkg::OP_A: a_q <= prod[49:23];
			avb_pkg::OP_Y1: begin
				c_q <= avb_pkg::C_ONE - avb_pkg::C_W'(a_q) - avb_pkg::C_W'(b_q);
				acc_q <= prod_acc;
			end
			avb_pkg::OP_Y2: acc_q <= acc_q + prod_acc;
			avb_pkg::OP_PH: acc_q <= (acc_q <<< 2) + prod_acc;
			avb_pkg::OP_OUT: begin
				sample_q <= y_sat;
				block_end_q <= blk_q;
			end
			default: ;
		endcase
	end

	// Voice state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
			phase_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && retrigger) begin
				env_q <= cfg.env_depth;
			end else if (cmd.op == avb_pkg::OP_ENV) begin
				env_q <= env_sat;
			end
			if (cmd.op == avb_pkg::OP_OUT) begin
				y2_q <= y1_q;
				y1_q <= y_sat;
				phase_q <= ph_wrap[avb_pkg::PH_W-1:0];
				out_valid_q <= 1'b1;
			end else if (voice.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign voice.valid = out_valid_q;
	assign voice.sample = sample_q;
	assign voice.block_end = block_end_q;

	assign status.run = cfg.run;
	assign status.out_free = !out_valid_q || voice.ready;

endmodule

/* design/acid_bass_voice.sv */
// Acid bass voice top level: sawtooth oscillator into a two-pole resonant lowpass.
// Each accepted tick on the tick channel makes one filtered sample on the voice channel
// while run is set; with run clear a tick is taken and dropped with no state change.
// A sample runs from the accepted request to the result in the output register through
// these steps: an accept step, eight products on the single shared 33x33 multiplier
// (filter angle scaling, angle to cosine phase, envelope decay, k squared, 2k cos, and
// the three filter taps), and a writeback, held until the output register is free.
// The next tick is taken as soon as the writeback is done, even while that result
// still waits in the output register, never mid-sample. The exp and cosine tables are
// constant ROMs read through registered indexes. Config writes are always accepted and
// must only be made while the voice is idle; writes to unused indexes are ignored.
module acid_bass_voice (
	input logic        clk,
	input logic        arst_n,
	avb_tick_if.sink   tick,
	avb_voice_if.source voice,
	avb_cfg_if.sink    cfg
);

	avb_pkg::cfg_t       regs;
	avb_pkg::dp_cmd_t    cmd;
	avb_pkg::dp_status_t status;
	logic                tick_ready;

	avb_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	avb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tick.valid),
		.in_ready (tick_ready),
		.status   (status),
		.cmd      (cmd)
	);

	avb_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (regs),
		.cmd           (cmd),
		.status        (status),
		.retrigger     (tick.retrigger),
		.last_in_block (tick.last_in_block),
		.voice         (voice)
	);

	assign tick.ready = tick_ready;

endmodule

/* design/avb_checker.sv */
// Port-level checks for the acid bass voice, bound to the top level.
module avb_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    tick_ready,
	input logic                                    voice_valid,
	input logic                                    voice_ready,
	input logic signed [avb_pkg::SAMPLE_WIDTH-1:0] sample,
	input logic                                    block_end,
	input logic                                    cfg_valid,
	input logic                                    cfg_ready
);

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		voice_valid && !voice_ready |=> voice_valid && $stable(sample) && $stable(block_end))
		else $error("voice result changed while stalled");

	// A new result only follows a busy stretch in which no request was taken
	a_out_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(voice_valid) |-> $past(!tick_ready, 1) && $past(!tick_ready, 9))
		else $error("result appeared without a full busy sequence");

	// Config writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind acid_bass_voice avb_checker u_avb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.tick_ready  (tick.ready),
	.voice_valid (voice.valid),
	.voice_ready (voice.ready),
	.sample      (voice.sample),
	.block_end   (voice.block_end),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready)
);

/* verif/acid_bass_voice_tb.sv */
// Testbench for the acid bass voice: predicted samples checked against random and directed ticks.
module acid_bass_voice_tb;

	localparam int SAMPLE_WIDTH    = avb_pkg::SAMPLE_WIDTH;
	localparam int EXP_TABLE_DEPTH = avb_pkg::EXP_TABLE_DEPTH;
	localparam int COS_TABLE_DEPTH = avb_pkg::COS_TABLE_DEPTH;
	localparam int CFG_DATA_W      = avb_pkg::CFG_DATA_W;

	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 24;   // margin after the last sample for the datapath to go idle
	localparam int HOLD_CYCLES   = 300;  // long back-pressure stretch
	localparam int IDLE_LIMIT    = 2000; // cycles with no handshake at all
	localparam int RANDOM_TICKS  = 700;
	localparam int CALM_TICKS    = 100;  // tail of the run with no idling

	localparam longint UNIT_Q30  = 64'sd1073741824;
	localparam longint UNIT_Q24  = 64'sd16777216;
	localparam longint TWO_PI_FX = 64'sd6746518852;
	localparam longint INV_PI_FX = 64'sd1367130551;
	localparam longint PH_HALF_V = 64'sd4194304;
	localparam longint PH_ONE_V  = 64'sd8388608;
	localparam longint Y_TOP     = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
	localparam longint Y_BOTTOM  = -(64'sd1 <<< (SAMPLE_WIDTH - 1));

	typedef struct {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           block_end;
	} voice_out_t;

	// Sawtooth through the resonant lowpass, one tick at a time
	class saw_filter_calc;
		bit        run_en;
		bit [22:0] step;
		bit [23:0] base;
		bit [23:0] depth;
		bit [24:0] decay;
		bit [15:0] inv_res;

		longint phase;
		longint env;
		longint y1;
		longint y2;

		longint k_rom [EXP_TABLE_DEPTH];
		longint cos_rom [COS_TABLE_DEPTH];

		voice_out_t due_samples [$];
		int         bad_count;

		function new();
			for (int i = 0; i < EXP_TABLE_DEPTH; i++)
				k_rom[i] = k_point(i);
			for (int j = 0; j < COS_TABLE_DEPTH; j++)
				cos_rom[j] = cos_point(j);
			run_en = 1'b0;
			step = '0;
			base = '0;
			depth = '0;
			decay = '0;
			inv_res = 16'd4096;
			phase = 0;
			env = 0;
			y1 = 0;
			y2 = 0;
			bad_count = 0;
		endfunction

		// exp(-16 i / D): Taylor series in Q30, squared four times, rounded to Q24
		function longint k_point(int i);
			longint f;
			longint term;
			longint sum;
			f = (longint'(i) <<< 30) / EXP_TABLE_DEPTH;
			term = UNIT_Q30;
			sum = UNIT_Q30;
			for (int n = 1; n <= 12; n++) begin
				term = ((term * f) >>> 30) / n;
				if (n % 2) sum -= term;
				else sum += term;
			end
			if (sum < 0) sum = 0;
			if (sum > UNIT_Q30) sum = UNIT_Q30;
			for (int n = 0; n < 4; n++)
				sum = (sum * sum + (UNIT_Q30 >>> 1)) >>> 30;
			return (sum + 32) >>> 6;
		endfunction

		// cos(2 pi j / D) in Q24, folded into the first quadrant
		function longint cos_point(int j);
			longint v;
			longint x;
			longint x2;
			longint term;
			longint sum;
			bit     neg;
			v = (longint'(j) <<< 30) / COS_TABLE_DEPTH;
			neg = 1'b0;
			term = UNIT_Q30;
			sum = UNIT_Q30;
			if (v >= (UNIT_Q30 >>> 1)) v = UNIT_Q30 - v;
			if (v > (UNIT_Q30 >>> 2)) begin
				neg = 1'b1;
				v = (UNIT_Q30 >>> 1) - v;
			end
			x = (v * TWO_PI_FX) >>> 30;
			x2 = (x * x) >>> 30;
			for (int n = 1; n <= 8; n++) begin
				term = ((term * x2) >>> 30) / ((2 * n - 1) * (2 * n));
				if (n % 2) sum -= term;
				else sum += term;
			end
			if (sum < 0) sum = 0;
			sum = (sum + 32) >>> 6;
			if (sum > UNIT_Q24) sum = UNIT_Q24;
			return neg ? -sum : sum;
		endfunction

		function void set_reg(avb_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				avb_pkg::REG_RUN:            run_en = v[0];
				avb_pkg::REG_PHASE_STEP:     step = v[22:0];
				avb_pkg::REG_BASE_CUTOFF:    base = v[23:0];
				avb_pkg::REG_ENV_DEPTH:      depth = v[23:0];
				avb_pkg::REG_ENV_DECAY_MULT: decay = v[24:0];
				avb_pkg::REG_INV_RES_COEFF:  inv_res = v[15:0];
				default: ;
			endcase
		endfunction

		// One accepted tick: advance the voice and queue the sample it makes
		function void take_tick(bit retrig, bit blk_end);
			longint w;
			longint x;
			longint idx;
			longint k;
			longint prod;
			longint frac;
			longint cs;
			longint a;
			longint b;
			longint c;
			longint acc;
			longint y;
			voice_out_t r;
			if (!run_en) return;
			if (retrig) env = longint'(depth);

			// filter angle picks the damping and the pole angle
			w = longint'(base) + env;
			x = w * longint'(inv_res);
			idx = (x * EXP_TABLE_DEPTH) >>> 38;
			k = (idx < EXP_TABLE_DEPTH) ? k_rom[int'(idx)] : 0;
			prod = w * INV_PI_FX;
			frac = (prod >>> 24) & 64'sh3FFF_FFFF;
			cs = cos_rom[int'((frac * COS_TABLE_DEPTH) >>> 30)];

			// envelope decay, saturating above one
			env = (env * longint'(decay)) >>> 24;
			if (env > 64'sh00FF_FFFF) env = 64'sh00FF_FFFF;

			// two-pole filter
			a = (2 * k * cs) >>> 24;
			b = -((k * k) >>> 24);
			c = UNIT_Q24 - a - b;
			acc = 4 * (a * y1 + b * y2) + c * phase;
			y = acc >>> 26;
			if (y > Y_TOP) y = Y_TOP;
			if (y < Y_BOTTOM) y = Y_BOTTOM;
			y2 = y1;
			y1 = y;

			r.sample = SAMPLE_WIDTH'(y);
			r.block_end = blk_end;
			due_samples.push_back(r);

			// sawtooth wraps by one above one half
			phase += longint'(step);
			if (phase > PH_HALF_V) phase -= PH_ONE_V;
		endfunction

		function void check_sample(logic signed [SAMPLE_WIDTH-1:0] s, logic be);
			voice_out_t e;
			if (due_samples.size() == 0) begin
				bad_count++;
				$display("%0t: sample with none expected: expected nothing, actual %0d/%0b",
					$time, s, be);
				return;
			end
			e = due_samples.pop_front();
			if (s !== e.sample) begin
				bad_count++;
				$display("%0t: sample mismatch: expected %0d, actual %0d",
					$time, e.sample, s);
			end
			if (be !== e.block_end) begin
				bad_count++;
				$display("%0t: block_end mismatch: expected %0b, actual %0b",
					$time, e.block_end, be);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   quiet_cycles;
	bit   hold_req;
	bit   rx_idle_on;

	saw_filter_calc calc;

	avb_tick_if  tick();
	avb_voice_if voice();
	avb_cfg_if   cfg();

	acid_bass_voice i_dut (
		.clk,
		.arst_n,
		.tick  (tick),
		.voice (voice),
		.cfg   (cfg)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Result checking and the no-progress watchdog
	always @(posedge clk) begin
		if (arst_n && voice.valid && voice.ready)
			calc.check_sample(voice.sample, voice.block_end);
		if (!arst_n || (tick.valid && tick.ready) || (voice.valid && voice.ready) ||
			(cfg.valid && cfg.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result side: random stall bursts, plus one long hold-off on request
	initial begin
		voice.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				voice.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
				voice.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end else begin
				voice.ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	// Offer one tick and hold it until taken; returns at a falling edge, valid still high
	task automatic send_tick(input bit retrig, input bit blk_end);
		tick.valid <= 1'b1;
		tick.retrigger <= retrig;
		tick.last_in_block <= blk_end;
		do @(posedge clk); while (!tick.ready);
		calc.take_tick(retrig, blk_end);
		@(negedge clk);
	endtask

	task automatic tick_gap(input int n);
		tick.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic write_reg(input avb_pkg::cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		calc.set_reg(idx, v);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_voice_regs(input bit run_v, input logic [22:0] step_v,
		input logic [23:0] base_v, input logic [23:0] depth_v,
		input logic [24:0] decay_v, input logic [15:0] inv_v);
		write_reg(avb_pkg::REG_RUN, CFG_DATA_W'(run_v));
		write_reg(avb_pkg::REG_PHASE_STEP, CFG_DATA_W'(step_v));
		write_reg(avb_pkg::REG_BASE_CUTOFF, CFG_DATA_W'(base_v));
		write_reg(avb_pkg::REG_ENV_DEPTH, CFG_DATA_W'(depth_v));
		write_reg(avb_pkg::REG_ENV_DECAY_MULT, CFG_DATA_W'(decay_v));
		write_reg(avb_pkg::REG_INV_RES_COEFF, CFG_DATA_W'(inv_v));
	endtask

	// Wait until every sample is out and the datapath has gone quiet
	task automatic settle();
		while (calc.due_samples.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_regs(input bit force_run);
		bit          run_v;
		logic [22:0] step_v;
		logic [23:0] base_v;
		logic [23:0] depth_v;
		logic [24:0] decay_v;
		logic [15:0] inv_v;
		run_v = force_run || ($urandom_range(0, 7) != 0);
		case ($urandom_range(0, 5))
			0:       step_v = '0;
			1:       step_v = 23'h40_0000;
			2:       step_v = 23'h7F_FFFF;
			3:       step_v = 23'($urandom);
			default: step_v = 23'($urandom_range(1, 200000));
		endcase
		case ($urandom_range(0, 4))
			0:       base_v = '0;
			1:       base_v = 24'hFF_FFFF;
			2:       base_v = 24'($urandom);
			default: base_v = 24'($urandom_range(0, 2000000));
		endcase
		case ($urandom_range(0, 4))
			0:       depth_v = '0;
			1:       depth_v = 24'hFF_FFFF;
			2:       depth_v = 24'($urandom);
			default: depth_v = 24'($urandom_range(0, 4000000));
		endcase
		case ($urandom_range(0, 5))
			0:       decay_v = '0;
			1:       decay_v = 25'h100_0000;
			2:       decay_v = 25'h1FF_FFFF;
			3:       decay_v = 25'($urandom);
			default: decay_v = 25'($urandom_range(15000000, 16777216));
		endcase
		case ($urandom_range(0, 4))
			0:       inv_v = '0;
			1:       inv_v = 16'hFFFF;
			2:       inv_v = 16'd4096;
			default: inv_v = 16'($urandom);
		endcase
		load_voice_regs(run_v, step_v, base_v, depth_v, decay_v, inv_v);
	endtask

	// Notes split into blocks: retrigger at note starts, last_in_block closes a block;
	// a few ticks carry random flags
	task automatic play_ticks(input int count, input bit gaps_on);
		int block_left;
		bit retrig;
		bit blk_end;
		block_left = $urandom_range(1, 32);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 7) == 0) begin
				retrig = 1'($urandom);
				blk_end = 1'($urandom);
			end else begin
				retrig = (n == 0) || ($urandom_range(0, 5) == 0);
				block_left--;
				blk_end = (block_left == 0);
				if (blk_end) block_left = $urandom_range(1, 32);
			end
			send_tick(retrig, blk_end);
			if (gaps_on && $urandom_range(0, 3) == 0)
				tick_gap($urandom_range(1, 8));
		end
		tick_gap(1);
	endtask

	initial begin
		int done_ticks;
		int len;
		int phase_no;
		bit calm;
		arst_n = 1'b0;
		tick.valid = 1'b0;
		tick.retrigger = 1'b0;
		tick.last_in_block = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		hold_req = 1'b0;
		rx_idle_on = 1'b0;
		quiet_cycles = 0;
		calc = new();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// run still off from reset: ticks are taken and dropped
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		tick_gap(1);
		settle();

		// low extremes, step of one half
		load_voice_regs(1'b1, 23'h40_0000, 24'd0, 24'd0, 25'd0, 16'd0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		tick_gap(1);
		settle();

		// undamped pole at cos = -1 driven at Nyquist runs into saturation
		load_voice_regs(1'b1, 23'h40_0000, 24'd6588398, 24'd0, 25'd0, 16'd16);
		for (int n = 0; n < 8; n++)
			send_tick(1'b0, n == 7);
		tick_gap(1);
		settle();

		// large angle product, decay above one, step above one half
		load_voice_regs(1'b1, 23'h7F_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 25'h1FF_FFFF, 16'hFFFF);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		tick_gap(1);
		settle();

		// ordinary note with unity decay
		load_voice_regs(1'b1, 23'd54321, 24'd300000, 24'd2000000, 25'h100_0000, 16'd4096);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		tick_gap(1);
		settle();

		// random phases, each with a fresh register set
		done_ticks = 0;
		phase_no = 0;
		while (done_ticks < RANDOM_TICKS) begin
			len = $urandom_range(20, 60);
			calm = (done_ticks + len > RANDOM_TICKS - CALM_TICKS);
			random_regs(phase_no == 2);
			rx_idle_on = !calm && ($urandom_range(0, 2) != 0);
			if (phase_no == 2) hold_req = 1'b1;
			play_ticks(len, !calm && ($urandom_range(0, 2) != 0));
			settle();
			done_ticks += len;
			phase_no++;
		end

		if (calc.bad_count == 0 && calc.due_samples.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* filelist.f */
design/avb_pkg.sv
design/avb_ifs.sv
design/avb_regs.sv
design/avb_ctrl.sv
design/avb_dpath.sv
design/acid_bass_voice.sv
design/avb_checker.sv
verif/acid_bass_voice_tb.sv
